>>> src/b2d_pkg.sv
// Package with types, constants and helpers shared by the binned two-axis lookup table.
package b2d_pkg;

	localparam int MAX_BINS_X = 32;
	localparam int MAX_BINS_Y = 32;

	localparam int VAL_W = 32;
	localparam int KIND_W = 3;
	localparam int EIDX_W = 6;
	localparam int CNT_W = 6;
	localparam int BIN_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam int EDGE_X_DEPTH = MAX_BINS_X + 1;
	localparam int EDGE_Y_DEPTH = MAX_BINS_Y + 1;
	localparam int EDGE_MAX_DEPTH = (EDGE_X_DEPTH > EDGE_Y_DEPTH) ? EDGE_X_DEPTH : EDGE_Y_DEPTH;
	localparam int EA_W = $clog2(EDGE_MAX_DEPTH);

	localparam int CELL_DEPTH = MAX_BINS_X * MAX_BINS_Y;
	localparam int CELL_W = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

	localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_EDGE  = 3'd0,
		KIND_PRIOR = 3'd1,
		KIND_ERROR = 3'd2,
		KIND_READ  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BINS_X = 1'd0,
		CFG_BINS_Y = 1'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_EDGE_CMP,
		ST_LOC_START,
		ST_LOC_HI,
		ST_LOC_SCAN,
		ST_CELL,
		ST_CELL_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic                    axis;
		logic [EIDX_W-1:0]       edge_index;
		logic signed [VAL_W-1:0] edge_value;
		logic signed [VAL_W-1:0] coord_x;
		logic signed [VAL_W-1:0] coord_y;
		logic signed [VAL_W-1:0] cell_value;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] prior_out;
		logic signed [VAL_W-1:0] error_out;
		logic [BIN_W-1:0]        bin_x_out;
		logic [BIN_W-1:0]        bin_y_out;
		logic                    out_of_range;
		logic                    not_probability;
		logic                    order_error;
	} result_t;

	typedef struct packed {
		logic ge;
		logic gt;
	} cmp_t;

	function automatic logic [EA_W-1:0] eff_bins(input logic [CNT_W-1:0] r, input int maxv);
		if (r == '0) begin
			eff_bins = EA_W'(1);
		end else if (int'(r) > maxv) begin
			eff_bins = EA_W'(maxv);
		end else begin
			eff_bins = EA_W'(r);
		end
	endfunction

endpackage

>>> src/b2d_cmp.sv
// Shared signed comparator used for edge order checks, range checks and the bin scan.
module b2d_cmp (
	input  logic signed [b2d_pkg::VAL_W-1:0] a,
	input  logic signed [b2d_pkg::VAL_W-1:0] b,
	output b2d_pkg::cmp_t                    res
);
	import b2d_pkg::*;

	logic [VAL_W:0] diff;

	assign diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};

	always_comb begin
		res.ge = ~diff[VAL_W];
		res.gt = ~diff[VAL_W] & (a != b);
	end

endmodule

>>> src/b2d_edge_mem.sv
// Bin edge memories for both axes with one shared address and a registered read.
module b2d_edge_mem (
	input  logic                             clk,
	input  logic                             axis,
	input  logic [b2d_pkg::EA_W-1:0]         addr,
	input  logic                             we,
	input  logic signed [b2d_pkg::VAL_W-1:0] wdata,
	output logic signed [b2d_pkg::VAL_W-1:0] rdata
);
	import b2d_pkg::*;

	logic signed [VAL_W-1:0] mem_x_q [EDGE_X_DEPTH];
	logic signed [VAL_W-1:0] mem_y_q [EDGE_Y_DEPTH];
	logic signed [VAL_W-1:0] rd_x_q;
	logic signed [VAL_W-1:0] rd_y_q;
	logic                    axis_q;

	always_ff @(posedge clk) begin
		if (we && !axis) begin
			mem_x_q[addr] <= wdata;
		end
		if (we && axis) begin
			mem_y_q[addr] <= wdata;
		end
		rd_x_q <= mem_x_q[addr];
		rd_y_q <= mem_y_q[addr];
		axis_q <= axis;
	end

	assign rdata = axis_q ? rd_y_q : rd_x_q;

endmodule

>>> src/b2d_cell_mem.sv
// Prior and error tables sharing one address with registered reads.
module b2d_cell_mem (
	input  logic                             clk,
	input  logic [b2d_pkg::CELL_W-1:0]       addr,
	input  logic                             we_prior,
	input  logic                             we_error,
	input  logic signed [b2d_pkg::VAL_W-1:0] wdata,
	output logic signed [b2d_pkg::VAL_W-1:0] prior_rd,
	output logic signed [b2d_pkg::VAL_W-1:0] error_rd
);
	import b2d_pkg::*;

	logic signed [VAL_W-1:0] prior_q [CELL_DEPTH];
	logic signed [VAL_W-1:0] error_q [CELL_DEPTH];

	always_ff @(posedge clk) begin
		if (we_prior) begin
			prior_q[addr] <= wdata;
		end
		if (we_error) begin
			error_q[addr] <= wdata;
		end
		prior_rd <= prior_q[addr];
		error_rd <= error_q[addr];
	end

endmodule

>>> src/binned_2d_lookup_table_core.sv
// Top level of the binned two-axis lookup table with its sequencer and result register.
//
// Items enter on the item channel (item_valid, item_stall, item) and one result word
// per item leaves on the result channel (result_valid, result_stall, result). The bin
// counts are written on the cfg channel, index 0 for X and 1 for Y; the user must write them
// only while idle, as the block itself does not enforce it. One item is processed at a
// time; item_stall is high while an item is in work. A cell access locates each axis by
// a linear lower-bound scan through the single-ported edge memory and one shared
// comparator; an axis whose bin count is zero is not scanned. The table access follows
// the scans. A clear item sweeps both tables one cell per cycle.
// After reset the same sweep runs before the first item is taken.
// A finished result waits in an output register while the next item is accepted;
// if the receiver stalls, the sequencer holds its next result until that register
// frees up.
module binned_2d_lookup_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  b2d_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output b2d_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [b2d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [b2d_pkg::CNT_W-1:0]        cfg_data
);
	import b2d_pkg::*;

	state_t            state_q, state_d;
	item_t             item_q;
	result_t           res_q, res_d;
	result_t           out_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  bins_x_q, bins_y_q;
	logic              ax_q, ax_d;
	logic [EA_W-1:0]   idx_q, idx_d;
	logic [EA_W-1:0]   bin_x_q, bin_x_d, bin_y_q, bin_y_d;
	logic [CELL_W-1:0] clr_q, clr_d;
	logic              clr_item_q, clr_item_d;

	logic                    out_load;
	logic [EA_W-1:0]         nx, ny, n_c;
	logic                    reg_zero;
	logic signed [VAL_W-1:0] coord_c;
	logic signed [VAL_W-1:0] cmp_b;
	cmp_t                    cmp;
	int                      emax_c;

	logic                    em_axis;
	logic [EA_W-1:0]         em_addr;
	logic                    em_we;
	logic signed [VAL_W-1:0] em_rd;

	logic [CELL_W-1:0]       cm_addr;
	logic                    cm_we_prior, cm_we_error;
	logic signed [VAL_W-1:0] cm_wdata;
	logic signed [VAL_W-1:0] cm_prior_rd, cm_error_rd;
	logic [2*EA_W-1:0]       prod_c;
	logic [CELL_W-1:0]       cell_c;
	logic                    bin_done;
	logic [EA_W-1:0]         bin_val;

	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign nx       = eff_bins(bins_x_q, MAX_BINS_X);
	assign ny       = eff_bins(bins_y_q, MAX_BINS_Y);
	assign n_c      = ax_q ? ny : nx;
	assign reg_zero = ax_q ? (bins_y_q == '0) : (bins_x_q == '0);
	assign coord_c  = ax_q ? item_q.coord_y : item_q.coord_x;
	assign cmp_b    = (state_q == ST_EDGE_CMP) ? item_q.edge_value : coord_c;
	assign emax_c   = item_q.axis ? MAX_BINS_Y : MAX_BINS_X;
	assign em_axis  = (item_q.kind == KIND_EDGE) ? item_q.axis : ax_q;
	assign prod_c   = nx * bin_y_q;
	assign cell_c   = CELL_W'(prod_c) + CELL_W'(bin_x_q);
	assign cm_wdata = (state_q == ST_CLEAR) ? '0 : item_q.cell_value;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !result_stall);

	b2d_cmp u_cmp (
		.a   (em_rd),
		.b   (cmp_b),
		.res (cmp)
	);

	b2d_edge_mem u_edge_mem (
		.clk   (clk),
		.axis  (em_axis),
		.addr  (em_addr),
		.we    (em_we),
		.wdata (item_q.edge_value),
		.rdata (em_rd)
	);

	b2d_cell_mem u_cell_mem (
		.clk      (clk),
		.addr     (cm_addr),
		.we_prior (cm_we_prior),
		.we_error (cm_we_error),
		.wdata    (cm_wdata),
		.prior_rd (cm_prior_rd),
		.error_rd (cm_error_rd)
	);

	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		ax_d        = ax_q;
		idx_d       = idx_q;
		bin_x_d     = bin_x_q;
		bin_y_d     = bin_y_q;
		clr_d       = clr_q;
		clr_item_d  = clr_item_q;
		em_addr     = idx_q;
		em_we       = 1'b0;
		cm_addr     = cell_c;
		cm_we_prior = 1'b0;
		cm_we_error = 1'b0;
		bin_done    = 1'b0;
		bin_val     = '0;
		case (state_q)
			ST_CLEAR: begin
				cm_addr     = clr_q;
				cm_we_prior = 1'b1;
				cm_we_error = 1'b1;
				if (clr_q == CELL_W'(CELL_DEPTH - 1)) begin
					clr_d   = '0;
					state_d = clr_item_q ? ST_OUT : ST_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				res_d      = '0;
				ax_d       = 1'b0;
				clr_item_d = 1'b0;
				case (item_q.kind)
					KIND_EDGE: begin
						if (int'(item_q.edge_index) > emax_c) begin
							state_d = ST_OUT;
						end else if (item_q.edge_index == '0) begin
							em_addr = '0;
							em_we   = 1'b1;
							state_d = ST_OUT;
						end else begin
							em_addr = EA_W'(item_q.edge_index - 1'b1);
							state_d = ST_EDGE_CMP;
						end
					end
					KIND_PRIOR, KIND_ERROR, KIND_READ: begin
						state_d = ST_LOC_START;
					end
					KIND_CLEAR: begin
						clr_item_d = 1'b1;
						clr_d      = '0;
						state_d    = ST_CLEAR;
					end
					default: begin
						state_d = ST_OUT;
					end
				endcase
			end
			ST_EDGE_CMP: begin
				res_d.order_error = cmp.ge;
				em_addr           = EA_W'(item_q.edge_index);
				em_we             = 1'b1;
				state_d           = ST_OUT;
			end
			ST_LOC_START: begin
				if (reg_zero) begin
					bin_done = 1'b1;
				end else begin
					em_addr = n_c;
					state_d = ST_LOC_HI;
				end
			end
			ST_LOC_HI: begin
				if (!cmp.ge) begin
					res_d              = '0;
					res_d.out_of_range = 1'b1;
					state_d            = ST_OUT;
				end else begin
					em_addr = '0;
					idx_d   = '0;
					state_d = ST_LOC_SCAN;
				end
			end
			ST_LOC_SCAN: begin
				if (idx_q == '0 && cmp.gt) begin
					res_d              = '0;
					res_d.out_of_range = 1'b1;
					state_d            = ST_OUT;
				end else if (cmp.ge) begin
					bin_done = 1'b1;
					bin_val  = (idx_q == '0) ? '0 : idx_q - 1'b1;
				end else if (idx_q == n_c - 1'b1) begin
					bin_done = 1'b1;
					bin_val  = n_c - 1'b1;
				end else begin
					idx_d   = idx_q + 1'b1;
					em_addr = idx_q + 1'b1;
				end
			end
			ST_CELL: begin
				res_d.bin_x_out = BIN_W'(bin_x_q);
				res_d.bin_y_out = BIN_W'(bin_y_q);
				case (item_q.kind)
					KIND_PRIOR: begin
						cm_we_prior           = 1'b1;
						res_d.not_probability = (item_q.cell_value < 0) ||
							(item_q.cell_value > Q_ONE);
						state_d               = ST_OUT;
					end
					KIND_ERROR: begin
						cm_we_error = 1'b1;
						state_d     = ST_OUT;
					end
					default: begin
						state_d = ST_CELL_RD;
					end
				endcase
			end
			ST_CELL_RD: begin
				res_d.prior_out = cm_prior_rd;
				res_d.error_out = cm_error_rd;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (bin_done) begin
			if (!ax_q) begin
				bin_x_d = bin_val;
				ax_d    = 1'b1;
				state_d = ST_LOC_START;
			end else begin
				bin_y_d = bin_val;
				state_d = ST_CELL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clr_item_q  <= 1'b0;
			out_valid_q <= 1'b0;
			bins_x_q    <= '0;
			bins_y_q    <= '0;
			ax_q        <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			clr_item_q <= clr_item_d;
			ax_q       <= ax_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BINS_X: bins_x_q <= cfg_data;
					CFG_BINS_Y: bins_y_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		res_q   <= res_d;
		idx_q   <= idx_d;
		bin_x_q <= bin_x_d;
		bin_y_q <= bin_y_d;
	end

endmodule
